// ===== rtl/mdfs_pkg.sv =====
// Shared types, codes and helpers of the maze backtracker block.
package mdfs_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Move directions; bit 0 separates the two senses of one axis.
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef struct packed {
    logic found;
    dir_e dir;
  } pick_t;

  // One cell of the maze store: visited flag, direction it was entered by, walls.
  typedef struct packed {
    logic       visited;
    dir_e       par;
    logic [3:0] walls;
  } entry_t;

  localparam logic CFG_GRID_ROWS = 1'b0;
  localparam logic CFG_GRID_COLS = 1'b1;

  localparam logic [4:0] GRID_RESET = 5'd16;
  localparam logic [3:0] ALL_WALLS  = 4'hF;

  // Candidate slots in search order: below, above, right, left.
  localparam dir_e CAND_DIR [4] = '{DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT};

  function automatic dir_e opposite(dir_e d);
    return dir_e'(d ^ 2'b01);
  endfunction

  function automatic logic [3:0] wall_bit(dir_e d);
    return 4'b0001 << d;
  endfunction

endpackage

// ===== rtl/maze_dfs_backtracker_unit.sv =====
// Top level of the depth-first maze carver with its cell store and sequencer.
//
// A transaction is accepted at a rising edge with start high and busy low; its
// result appears on the result ports for exactly one cycle, marked by
// res_valid_o, in the cycle after the work ends; the receiver cannot stall it,
// so capture it in that cycle. A step passes through S_RD0 and S_RD1
// (neighbour reads over the two read ports of the cell store) and S_DEC
// (decide and write back); a new step is accepted only once the block is idle
// again. A wall read passes through S_RDC and S_RSP (registered store read).
// Nop, a step after the walk has finished, and any start or read outside the
// grid answer at once. An in-grid start answers at once and then sweeps the
// cell store, one entry a cycle, while busy; the same sweep runs after reset.
// Configuration writes are taken at any time and must be made while idle.
module maze_dfs_backtracker_unit #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [4:0] cfg_wdata_i,
  // command
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [3:0] cell_row_i,
  input  logic [3:0] cell_col_i,
  input  logic [7:0] random_pick_i,
  // result
  output logic       res_valid_o,
  output logic [3:0] cur_row_o,
  output logic [3:0] cur_col_o,
  output logic       carved_o,
  output logic [1:0] carve_dir_o,
  output logic       finished_o,
  output logic [3:0] wall_bits_o,
  output logic       bad_cell_o
);
  import mdfs_pkg::*;

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int IW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int DW     = $clog2(NCELLS + 1);
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCAP   = (MAX_ROWS > 31) ? 31 : MAX_ROWS;
  localparam int CCAP   = (MAX_COLS > 31) ? 31 : MAX_COLS;
  localparam int EW     = $bits(entry_t);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_RD0   = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_DEC   = 7'b0010000,
    S_RDC   = 7'b0100000,
    S_RSP   = 7'b1000000
  } state_e;

  function automatic logic [IW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return IW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  function automatic logic [RW-1:0] row_step(logic [RW-1:0] r, dir_e d);
    logic [RW-1:0] res;
    case (d)
      DIR_DOWN: res = r + RW'(1);
      DIR_UP:   res = r - RW'(1);
      default:  res = r;
    endcase
    return res;
  endfunction

  function automatic logic [CW-1:0] col_step(logic [CW-1:0] c, dir_e d);
    logic [CW-1:0] res;
    case (d)
      DIR_RIGHT: res = c + CW'(1);
      DIR_LEFT:  res = c - CW'(1);
      default:   res = c;
    endcase
    return res;
  endfunction

  // Registers
  state_e        state_q, state_d;
  logic [4:0]    grid_rows_q, grid_cols_q;
  logic [IW-1:0] clr_q, clr_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [3:0]    cur_walls_q, cur_walls_d;
  dir_e          cur_par_q, cur_par_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          walk_done_q, walk_done_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_addr_q, pend_addr_d;
  entry_t        pend_data_q, pend_data_d;
  logic [IW-1:0] rd_addr_q, rd_addr_d;
  logic [7:0]    pick_q, pick_d;
  entry_t        nb_up_q, nb_dn_q;
  logic          res_valid_q, res_valid_d;
  logic          res_carved_q, res_carved_d;
  dir_e          res_dir_q, res_dir_d;
  logic [3:0]    res_walls_q, res_walls_d;
  logic          res_bad_q, res_bad_d;

  // Cell store ports
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  entry_t        mem_wdata;
  logic [EW-1:0] mem_rdata_a, mem_rdata_b;
  entry_t        rd_a, rd_b;

  // Grid and neighbour geometry
  logic [4:0]    rows_eff, cols_eff;
  logic          in_grid, accept;
  logic [8:0]    cr9, cc9;
  logic          phy_dn, phy_up, phy_rt, phy_lf;
  logic          in_dn, in_up, in_rt, in_lf;
  logic [IW-1:0] addr_cur, addr_dn, addr_up, addr_rt, addr_lf;
  logic [3:0]    cand;
  pick_t         pk;
  entry_t        nb [4];
  logic          carve;
  dir_e          pdir;
  entry_t        cur_wr;

  assign rd_a = entry_t'(mem_rdata_a);
  assign rd_b = entry_t'(mem_rdata_b);

  // Out-of-range sizes fold back into 1..MAX (31 at most)
  assign rows_eff = (grid_rows_q == 5'd0) ? 5'd1 :
                    (grid_rows_q > 5'(RCAP)) ? 5'(RCAP) : grid_rows_q;
  assign cols_eff = (grid_cols_q == 5'd0) ? 5'd1 :
                    (grid_cols_q > 5'(CCAP)) ? 5'(CCAP) : grid_cols_q;

  assign in_grid = ({1'b0, cell_row_i} < rows_eff) && ({1'b0, cell_col_i} < cols_eff);

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Physical neighbours exist in the store; in-grid ones may be carved into.
  assign cr9    = 9'(cur_row_q);
  assign cc9    = 9'(cur_col_q);
  assign phy_dn = (cr9 + 9'd1) < 9'(MAX_ROWS);
  assign phy_up = (cr9 != 9'd0);
  assign phy_rt = (cc9 + 9'd1) < 9'(MAX_COLS);
  assign phy_lf = (cc9 != 9'd0);
  assign in_dn  = (cr9 + 9'd1) < 9'(rows_eff);
  assign in_up  = phy_up && ((cr9 - 9'd1) < 9'(rows_eff));
  assign in_rt  = (cc9 + 9'd1) < 9'(cols_eff);
  assign in_lf  = phy_lf && ((cc9 - 9'd1) < 9'(cols_eff));

  assign addr_cur = cell_addr(cur_row_q, cur_col_q);
  assign addr_dn  = phy_dn ? cell_addr(row_step(cur_row_q, DIR_DOWN), cur_col_q) : addr_cur;
  assign addr_up  = phy_up ? cell_addr(row_step(cur_row_q, DIR_UP), cur_col_q) : addr_cur;
  assign addr_rt  = phy_rt ? cell_addr(cur_row_q, col_step(cur_col_q, DIR_RIGHT)) : addr_cur;
  assign addr_lf  = phy_lf ? cell_addr(cur_row_q, col_step(cur_col_q, DIR_LEFT)) : addr_cur;

  // In the decide cycle below/above come from registers, right/left from the store.
  always_comb begin
    nb[DIR_UP]    = nb_up_q;
    nb[DIR_DOWN]  = nb_dn_q;
    nb[DIR_RIGHT] = rd_a;
    nb[DIR_LEFT]  = rd_b;
  end

  assign cand[0] = in_dn && !nb_dn_q.visited;
  assign cand[1] = in_up && !nb_up_q.visited;
  assign cand[2] = in_rt && !rd_a.visited;
  assign cand[3] = in_lf && !rd_b.visited;

  mdfs_pick u_pick (
    .cand_i (cand),
    .pick_i (pick_q),
    .pick_o (pk)
  );

  assign carve = pk.found && (depth_q < DW'(NCELLS));
  // The backtrack path is the chain of entry directions; pop walks it back.
  assign pdir  = opposite(cur_par_q);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    cur_walls_d  = cur_walls_q;
    cur_par_d    = cur_par_q;
    depth_d      = depth_q;
    walk_done_d  = walk_done_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    pend_data_d  = pend_data_q;
    rd_addr_d    = rd_addr_q;
    pick_d       = pick_q;
    res_valid_d  = 1'b0;
    res_carved_d = res_carved_q;
    res_dir_d    = res_dir_q;
    res_walls_d  = res_walls_q;
    res_bad_d    = res_bad_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_cur;
    mem_wdata    = '0;
    mem_raddr_a  = addr_cur;
    mem_raddr_b  = addr_cur;
    cur_wr       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_carved_d = 1'b0;
          res_dir_d    = DIR_UP;
          res_walls_d  = 4'd0;
          res_bad_d    = 1'b0;
          case (op_e'(operation_i))
            OP_START: begin
              res_valid_d = 1'b1;
              if (!in_grid) begin
                res_bad_d = 1'b1;
              end else begin
                cur_row_d   = RW'(cell_row_i);
                cur_col_d   = CW'(cell_col_i);
                cur_walls_d = ALL_WALLS;
                cur_par_d   = DIR_UP;
                depth_d     = '0;
                walk_done_d = 1'b0;
                clr_d       = '0;
                state_d     = S_CLEAR;
              end
            end
            OP_STEP: begin
              if (walk_done_q) begin
                res_valid_d = 1'b1;
              end else begin
                pick_d  = random_pick_i;
                state_d = S_RD0;
              end
            end
            OP_READ: begin
              if (!in_grid) begin
                res_valid_d = 1'b1;
                res_bad_d   = 1'b1;
              end else begin
                rd_addr_d = cell_addr(RW'(cell_row_i), CW'(cell_col_i));
                state_d   = S_RDC;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        // Sweep: all walls back, nothing visited
        mem_we          = 1'b1;
        mem_waddr       = clr_q;
        mem_wdata.walls = ALL_WALLS;
        if (clr_q == IW'(NCELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IW'(1);
        end
      end
      S_RD0: begin
        mem_raddr_a = addr_dn;
        mem_raddr_b = addr_up;
        state_d     = S_RD1;
      end
      S_RD1: begin
        mem_raddr_a = addr_rt;
        mem_raddr_b = addr_lf;
        state_d     = S_DEC;
      end
      S_DEC: begin
        // Write back the current cell, visited, with its wall opened on a carve
        cur_wr.visited = 1'b1;
        cur_wr.par     = cur_par_q;
        cur_wr.walls   = carve ? (cur_walls_q & ~wall_bit(pk.dir)) : cur_walls_q;
        mem_we         = 1'b1;
        mem_waddr      = addr_cur;
        mem_wdata      = cur_wr;
        res_valid_d    = 1'b1;
        res_carved_d   = carve;
        res_dir_d      = carve ? pk.dir : DIR_UP;
        res_walls_d    = 4'd0;
        res_bad_d      = 1'b0;
        state_d        = S_IDLE;
        if (carve) begin
          // Queue the neighbour write for the next cycle and move there
          pend_d              = 1'b1;
          cur_row_d           = row_step(cur_row_q, pk.dir);
          cur_col_d           = col_step(cur_col_q, pk.dir);
          pend_addr_d         = cell_addr(row_step(cur_row_q, pk.dir),
                                          col_step(cur_col_q, pk.dir));
          pend_data_d.visited = 1'b1;
          pend_data_d.par     = pk.dir;
          pend_data_d.walls   = nb[pk.dir].walls & ~wall_bit(opposite(pk.dir));
          cur_walls_d         = nb[pk.dir].walls & ~wall_bit(opposite(pk.dir));
          cur_par_d           = pk.dir;
          depth_d             = depth_q + DW'(1);
        end else if (depth_q != '0) begin
          // Dead end: back up to the cell we came from
          cur_row_d   = row_step(cur_row_q, pdir);
          cur_col_d   = col_step(cur_col_q, pdir);
          cur_walls_d = nb[pdir].walls;
          cur_par_d   = nb[pdir].par;
          depth_d     = depth_q - DW'(1);
          if (depth_q == DW'(1)) begin
            walk_done_d = 1'b1;
          end
        end else begin
          walk_done_d = 1'b1;
        end
      end
      S_RDC: begin
        mem_raddr_a = rd_addr_q;
        state_d     = S_RSP;
      end
      S_RSP: begin
        res_valid_d  = 1'b1;
        res_carved_d = 1'b0;
        res_dir_d    = DIR_UP;
        res_walls_d  = rd_a.walls;
        res_bad_d    = 1'b0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The queued neighbour write lands in the idle cycle after a decide.
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_data_q;
    end
  end

  mdfs_ram #(
    .WIDTH (EW),
    .DEPTH (NCELLS)
  ) u_cells (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .rdata_a_o (mem_rdata_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_b_o (mem_rdata_b)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cur_walls_q <= ALL_WALLS;
      cur_par_q   <= DIR_UP;
      depth_q     <= '0;
      walk_done_q <= 1'b1;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      cur_walls_q <= cur_walls_d;
      cur_par_q   <= cur_par_d;
      depth_q     <= depth_d;
      walk_done_q <= walk_done_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRID_RESET;
      grid_cols_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_ROWS: grid_rows_q <= cfg_wdata_i;
        CFG_GRID_COLS: grid_cols_q <= cfg_wdata_i;
        default: begin
          grid_rows_q <= grid_rows_q;
        end
      endcase
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    pend_data_q  <= pend_data_d;
    rd_addr_q    <= rd_addr_d;
    pick_q       <= pick_d;
    res_carved_q <= res_carved_d;
    res_dir_q    <= res_dir_d;
    res_walls_q  <= res_walls_d;
    res_bad_q    <= res_bad_d;
    if (state_q == S_RD1) begin
      nb_dn_q <= rd_a;
      nb_up_q <= rd_b;
    end
  end

  // The current cell and walk flag already hold post-transaction values
  // during the strobe cycle.
  assign res_valid_o = res_valid_q;
  assign cur_row_o   = 4'(cur_row_q);
  assign cur_col_o   = 4'(cur_col_q);
  assign carved_o    = res_carved_q;
  assign carve_dir_o = res_dir_q;
  assign finished_o  = walk_done_q;
  assign wall_bits_o = res_walls_q;
  assign bad_cell_o  = res_bad_q;

endmodule

// ===== rtl/mdfs_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
module mdfs_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/mdfs_pick.sv =====
// Neighbour choice: random value mod candidate count, then the k-th candidate.
module mdfs_pick (
  input  logic [3:0]      cand_i,
  input  logic [7:0]      pick_i,
  output mdfs_pkg::pick_t pick_o
);
  import mdfs_pkg::*;

  logic [2:0]  n;
  logic [15:0] prod;
  logic [6:0]  quo;
  logic [7:0]  rem3;
  logic [1:0]  k;
  logic [2:0]  seen;

  always_comb begin
    n    = 3'($countones(cand_i));
    // x / 3 for 8-bit x as (x * 171) >> 9
    prod = 16'(pick_i) * 16'd171;
    quo  = prod[15:9];
    rem3 = pick_i - 8'(quo) * 8'd3;
    case (n)
      3'd2:    k = {1'b0, pick_i[0]};
      3'd3:    k = rem3[1:0];
      3'd4:    k = pick_i[1:0];
      default: k = 2'd0;
    endcase
    pick_o.found = (n != 3'd0);
    pick_o.dir   = DIR_UP;
    seen         = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_i[i]) begin
        if (seen == 3'(k)) begin
          pick_o.dir = CAND_DIR[i];
        end
        seen = seen + 3'd1;
      end
    end
  end

endmodule

// ===== tb/tb_maze_dfs_backtracker_unit.sv =====
// Self-checking testbench for the depth-first maze carver: directed and random walks.
module tb_maze_dfs_backtracker_unit;
  import mdfs_pkg::*;

  localparam int GRID_MAX   = 16;
  localparam int CELL_COUNT = GRID_MAX * GRID_MAX;
  // The longest quiet stretch of a correct run is the store sweep after an in-grid
  // start plus a sender gap; allow several times that.
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1000;

  typedef struct packed {
    op_e        op;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] pick;
  } maze_cmd_t;

  typedef struct packed {
    logic [3:0] row;
    logic [3:0] col;
    logic       carved;
    dir_e       dir;
    logic       done;
    logic [3:0] walls;
    logic       bad;
  } maze_report_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_idx_i     = 1'b0;
  logic [4:0] cfg_wdata_i   = '0;
  logic       start         = 1'b0;
  logic       busy;
  logic [1:0] operation_i   = '0;
  logic [3:0] cell_row_i    = '0;
  logic [3:0] cell_col_i    = '0;
  logic [7:0] random_pick_i = '0;
  logic       res_valid_o;
  logic [3:0] cur_row_o;
  logic [3:0] cur_col_o;
  logic       carved_o;
  logic [1:0] carve_dir_o;
  logic       finished_o;
  logic [3:0] wall_bits_o;
  logic       bad_cell_o;

  maze_dfs_backtracker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .random_pick_i(random_pick_i),
    .res_valid_o  (res_valid_o),
    .cur_row_o    (cur_row_o),
    .cur_col_o    (cur_col_o),
    .carved_o     (carved_o),
    .carve_dir_o  (carve_dir_o),
    .finished_o   (finished_o),
    .wall_bits_o  (wall_bits_o),
    .bad_cell_o   (bad_cell_o)
  );

  // Commands waiting for the driver, and reports the block still owes us.
  maze_cmd_t    maze_cmds [$];
  maze_report_t maze_reports [$];

  // Scoreboard copy of the maze: visited flags, walls, backtrack trail, walker.
  bit         cell_seen  [CELL_COUNT];
  logic [3:0] cell_walls [CELL_COUNT];
  int         trail      [CELL_COUNT];
  int         trail_depth;
  int         here_cell;
  bit         walk_over;
  logic [4:0] rows_cfg;
  logic [4:0] cols_cfg;

  int        in_flight;
  int        err_cnt;
  int        cmds_issued;
  int        idle_max;
  int        gap_left;
  int        stall_cnt;
  maze_cmd_t drive_cmd;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A register value of 0 behaves as 1, anything above the array size as the size.
  function automatic int eff_dim(logic [4:0] v);
    if (v == 0) return 1;
    return (int'(v) > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  // Apply one command to the scoreboard maze and return the report it must produce.
  function automatic maze_report_t advance_maze(maze_cmd_t cmd);
    int           rows, cols, cr, cc, n, k, nx;
    int           cand [4];
    dir_e         cdir [4];
    maze_report_t rep;
    rows = eff_dim(rows_cfg);
    cols = eff_dim(cols_cfg);
    rep  = '0;
    case (cmd.op)
      OP_START: begin
        if (int'(cmd.row) >= rows || int'(cmd.col) >= cols) begin
          rep.bad = 1'b1;
        end else begin
          for (int i = 0; i < CELL_COUNT; i++) begin
            cell_seen[i]  = 1'b0;
            cell_walls[i] = 4'hF;
          end
          trail_depth = 0;
          here_cell   = int'(cmd.row) * GRID_MAX + int'(cmd.col);
          walk_over   = 1'b0;
        end
      end
      OP_STEP: begin
        if (!walk_over) begin
          cr = here_cell / GRID_MAX;
          cc = here_cell % GRID_MAX;
          n  = 0;
          cell_seen[here_cell] = 1'b1;
          // Gather candidates below, above, right, left against the live grid size;
          // a walker left outside a shrunk grid simply finds fewer of them.
          if (cr + 1 < rows && !cell_seen[here_cell + GRID_MAX]) begin
            cand[n] = here_cell + GRID_MAX; cdir[n] = DIR_DOWN; n++;
          end
          if (cr >= 1 && cr - 1 < rows && !cell_seen[here_cell - GRID_MAX]) begin
            cand[n] = here_cell - GRID_MAX; cdir[n] = DIR_UP; n++;
          end
          if (cc + 1 < cols && !cell_seen[here_cell + 1]) begin
            cand[n] = here_cell + 1; cdir[n] = DIR_RIGHT; n++;
          end
          if (cc >= 1 && cc - 1 < cols && !cell_seen[here_cell - 1]) begin
            cand[n] = here_cell - 1; cdir[n] = DIR_LEFT; n++;
          end
          if (n > 0 && trail_depth < CELL_COUNT) begin
            k  = int'(cmd.pick) % n;
            nx = cand[k];
            rep.dir    = cdir[k];
            rep.carved = 1'b1;
            cell_seen[nx]      = 1'b1;
            trail[trail_depth] = here_cell;
            trail_depth++;
            // Knock out the wall on our side and the facing wall on the far side.
            cell_walls[here_cell] &= ~(4'b0001 << cdir[k]);
            cell_walls[nx]        &= ~(4'b0001 << (cdir[k] ^ 2'b01));
            here_cell = nx;
          end else if (trail_depth > 0) begin
            trail_depth--;
            here_cell = trail[trail_depth];
            if (trail_depth == 0) walk_over = 1'b1;
          end else begin
            // Dead end with nothing to pop, as on a single-cell grid.
            walk_over = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (int'(cmd.row) >= rows || int'(cmd.col) >= cols) rep.bad = 1'b1;
        else rep.walls = cell_walls[int'(cmd.row) * GRID_MAX + int'(cmd.col)];
      end
      default: begin
      end
    endcase
    rep.row  = 4'(here_cell / GRID_MAX);
    rep.col  = 4'(here_cell % GRID_MAX);
    rep.done = walk_over;
    return rep;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic queue_cmd(op_e op, int row, int col, int pick);
    maze_cmd_t cmd;
    cmd.op   = op;
    cmd.row  = 4'(row);
    cmd.col  = 4'(col);
    cmd.pick = 8'(pick);
    maze_cmds.insert(maze_cmds.size(), cmd);
    cmds_issued++;
  endtask

  // Hold until nothing is queued or owed and the block has stayed idle.
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 3) begin
      @(posedge clk_i);
      if (maze_cmds.size() == 0 && in_flight == 0 && !busy) quiet++;
      else quiet = 0;
    end
  endtask

  // Write one grid register; the scoreboard follows immediately since nothing is moving.
  task automatic write_cfg(logic idx, logic [4:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_GRID_ROWS) rows_cfg = val;
    else cols_cfg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [4:0] rand_dim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 5'($urandom_range(1, 5));
      6, 7:             return 5'($urandom_range(6, 16));
      8:                return 5'($urandom_range(17, 31));
      default:          return 5'd0;
    endcase
  endfunction

  // Driver: present one command at a time, hold it until accepted, then idle
  // for a random number of cycles before the next one.
  always @(posedge clk_i) begin : drv
    bit take;
    if (rst_ni) begin
      take = start && !busy;
      if (take) begin
        maze_reports.insert(maze_reports.size(), advance_maze(drive_cmd));
        gap_left = $urandom_range(0, idle_max);
      end
      if (!start || take) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (maze_cmds.size() > 0) begin
          drive_cmd = maze_cmds.pop_front();
          in_flight++;
          start         <= 1'b1;
          operation_i   <= drive_cmd.op;
          cell_row_i    <= drive_cmd.row;
          cell_col_i    <= drive_cmd.col;
          random_pick_i <= drive_cmd.pick;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed report must match the oldest outstanding transaction.
  always @(posedge clk_i) begin : mon
    maze_report_t want;
    if (rst_ni && res_valid_o) begin
      if (maze_reports.size() == 0) begin
        report_mismatch("report with no transaction outstanding");
      end else begin
        want = maze_reports.pop_front();
        in_flight--;
        check_field("cur_row",   cur_row_o,         want.row);
        check_field("cur_col",   cur_col_o,         want.col);
        check_field("carved",    4'(carved_o),      4'(want.carved));
        check_field("carve_dir", 4'(carve_dir_o),   4'(want.dir));
        check_field("finished",  4'(finished_o),    4'(want.done));
        check_field("wall_bits", wall_bits_o,       want.walls);
        check_field("bad_cell",  4'(bad_cell_o),    4'(want.bad));
      end
    end
  end

  // Watchdog: drop the run if nothing is accepted, reported or configured for too long.
  always @(posedge clk_i) begin
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst_ni || (start && !busy) || res_valid_o || cfg_we_i) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stim
    int nr, nc, walk_len;
    rows_cfg    = GRID_RESET;
    cols_cfg    = GRID_RESET;
    trail_depth = 0;
    here_cell   = 0;
    walk_over   = 1'b1;
    for (int i = 0; i < CELL_COUNT; i++) begin
      cell_seen[i]  = 1'b0;
      cell_walls[i] = 4'hF;
    end
    in_flight   = 0;
    err_cnt     = 0;
    cmds_issued = 0;
    idle_max    = 5;
    gap_left    = 0;
    stall_cnt   = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fresh out of reset: full grid, walk already finished, every wall standing.
    queue_cmd(OP_READ, 0, 0, 0);
    queue_cmd(OP_READ, 15, 15, 255);
    queue_cmd(OP_NOP, 0, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 0);
    queue_cmd(OP_START, 15, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 255);
    queue_cmd(OP_STEP, 0, 0, 0);
    queue_cmd(OP_READ, 15, 0, 0);
    wait_idle();

    // Single-cell grid: the first step hits a dead end with an empty trail.
    write_cfg(CFG_GRID_ROWS, 5'd1);
    write_cfg(CFG_GRID_COLS, 5'd1);
    queue_cmd(OP_START, 0, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 0);
    queue_cmd(OP_READ, 0, 0, 0);
    queue_cmd(OP_START, 0, 1, 0);
    queue_cmd(OP_READ, 1, 15, 0);
    wait_idle();

    // Zero rows acts as one, oversize columns clamp to the array: a 1x16 strip.
    write_cfg(CFG_GRID_ROWS, 5'd0);
    write_cfg(CFG_GRID_COLS, 5'd31);
    queue_cmd(OP_START, 0, 15, 0);
    queue_cmd(OP_STEP, 0, 0, 8'h80);
    queue_cmd(OP_STEP, 0, 0, 8'h7F);
    queue_cmd(OP_STEP, 0, 0, 0);
    queue_cmd(OP_READ, 0, 14, 0);
    wait_idle();

    // Shrink the grid under the walker: it now stands outside and must backtrack.
    write_cfg(CFG_GRID_COLS, 5'd2);
    queue_cmd(OP_STEP, 0, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 0);
    queue_cmd(OP_STEP, 0, 0, 0);
    wait_idle();
    write_cfg(CFG_GRID_ROWS, 5'd16);
    write_cfg(CFG_GRID_COLS, 5'd16);

    // Random walks: mostly a start followed by a run of steps, salted with
    // stray reads, no-ops and restarts; some phases resize without restarting.
    while (cmds_issued < ITEM_TARGET) begin
      wait_idle();
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      if ($urandom_range(0, 3) != 0) write_cfg(CFG_GRID_ROWS, rand_dim());
      if ($urandom_range(0, 3) != 0) write_cfg(CFG_GRID_COLS, rand_dim());
      nr = eff_dim(rows_cfg);
      nc = eff_dim(cols_cfg);
      if ($urandom_range(0, 3) != 0)
        queue_cmd(OP_START, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), $urandom);
      // Small grids get enough steps to finish the walk and step past the end.
      walk_len = (nr * nc <= 36) ? 2 * nr * nc + 2 : $urandom_range(20, 120);
      repeat (walk_len) begin
        if ($urandom_range(0, 11) == 0)
          queue_cmd(op_e'($urandom_range(0, 3)), $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom);
        queue_cmd(OP_STEP, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
